>>> sv/dlcs_pkg.sv
// ----------------------------------------------------------------------------
// dlcs_pkg: shared types and constants of the dual LFSR cross-skip generator
// Command codes, register indexes, reset values and counter widths.
// ----------------------------------------------------------------------------
package dlcs_pkg;

  localparam int unsigned SKIP_WIDTH          = 8;
  localparam int unsigned MAX_CROSS_SKIP_BITS = 8;
  localparam int unsigned CNT_W = ((SKIP_WIDTH > MAX_CROSS_SKIP_BITS) ?
                                   SKIP_WIDTH : MAX_CROSS_SKIP_BITS) + 1;

  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned STATE_W = 32;
  localparam int unsigned SKIPB_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_STEP_A = 2'd0,
    CMD_STEP_B = 2'd1,
    CMD_CROSS  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_A   = 3'd0,
    REG_TAPS_A    = 3'd1,
    REG_SEED_A    = 3'd2,
    REG_WIDTH_B   = 3'd3,
    REG_TAPS_B    = 3'd4,
    REG_SEED_B    = 3'd5,
    REG_SKIP_BITS = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_e;

  localparam logic [WIDTH_W-1:0] WIDTH_A_RST   = 6'd32;
  localparam logic [STATE_W-1:0] TAPS_A_RST    = 32'h8000_0057;
  localparam logic [STATE_W-1:0] SEED_A_RST    = 32'h0000_0000;
  localparam logic [WIDTH_W-1:0] WIDTH_B_RST   = 6'd30;
  localparam logic [STATE_W-1:0] TAPS_B_RST    = 32'h2000_0029;
  localparam logic [STATE_W-1:0] SEED_B_RST    = 32'h0000_0000;
  localparam logic [SKIPB_W-1:0] SKIP_BITS_RST = 4'd1;

  // Setup of one LFSR as seen by the advance unit.
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [STATE_W-1:0] taps;
  } lfsr_cfg_t;

endpackage

>>> sv/dlcs_in_if.sv
// ----------------------------------------------------------------------------
// dlcs_in_if: command channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface dlcs_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      cmd;
  logic [dlcs_pkg::SKIP_WIDTH-1:0] skip_count;

  modport source (output valid, output cmd, output skip_count, input ready);
  modport sink   (input valid, input cmd, input skip_count, output ready);
endinterface

>>> sv/dlcs_out_if.sv
// ----------------------------------------------------------------------------
// dlcs_out_if: result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface dlcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [dlcs_pkg::STATE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> sv/dual_lfsr_cross_skip_generator.sv
// ----------------------------------------------------------------------------
// dual_lfsr_cross_skip_generator: two Galois LFSRs with cross-skip combining
// Sequencer around a single shared LFSR advance unit.
// ----------------------------------------------------------------------------
// The block keeps two right-shifting Galois LFSRs, A and B, and serves one
// command beat at a time. Step A / step B advance that LFSR skip_count+1
// times and return its state. Cross-skip samples the low skip_bits of both
// states, advances A by B's sample plus one and then B by A's sample plus
// one, and returns A xor B. The unused command returns 0 and touches nothing.
// Both LFSRs share one advance unit, which does one advance per cycle while
// the sequencer is in its run states; a command is accepted in idle, does
// its advances, and then waits in the done state until the output register
// is free to take its result. A result sits in the output register until
// taken; the next command is accepted as soon as the sequencer is back in
// idle, even while that result still waits.
// Writing seed_a or seed_b loads the matching state at once. Write the
// configuration only while the block is idle. Register indexes follow the
// order width_a, taps_a, seed_a, width_b, taps_b, seed_b, skip_bits; writes
// to any other index are dropped. No clearing pass after reset.
// ----------------------------------------------------------------------------
module dual_lfsr_cross_skip_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  dlcs_in_if.sink                             in_ch,
  dlcs_out_if.source                          out_ch,
  input  logic                                cfg_we_i,
  input  logic [dlcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dlcs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN_A = 4'b0010,
    ST_RUN_B = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  localparam int unsigned CNT_W = dlcs_pkg::CNT_W;
  localparam int unsigned MCB   = dlcs_pkg::MAX_CROSS_SKIP_BITS;

  // configuration registers
  logic [dlcs_pkg::WIDTH_W-1:0] width_a_q, width_b_q;
  logic [dlcs_pkg::STATE_W-1:0] taps_a_q, taps_b_q;
  logic [dlcs_pkg::SKIPB_W-1:0] skip_bits_q;

  // LFSR states and sequencer
  logic [dlcs_pkg::STATE_W-1:0] lfsr_a_q, lfsr_a_d, lfsr_b_q, lfsr_b_d;
  state_e                       st_q, st_d;
  dlcs_pkg::cmd_e               cmd_q, cmd_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [CNT_W-1:0]             pend_q, pend_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [dlcs_pkg::STATE_W-1:0] out_value_q, out_value_d;

  // shared advance unit
  logic [dlcs_pkg::STATE_W-1:0] adv_in, adv_out;
  dlcs_pkg::lfsr_cfg_t          adv_cfg;

  logic                         in_fire;
  dlcs_pkg::cmd_e               in_cmd;
  logic [3:0]                   k_eff;
  logic [dlcs_pkg::STATE_W-1:0] mask_full;
  logic [MCB-1:0]               smp_a, smp_b;
  logic [dlcs_pkg::STATE_W-1:0] result;

  dlcs_adv_unit u_adv (
    .state_i (adv_in),
    .cfg_i   (adv_cfg),
    .next_o  (adv_out)
  );

  assign in_ch.ready  = (st_q == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_cmd       = dlcs_pkg::cmd_e'(in_ch.cmd);
  assign out_ch.valid = out_valid_q;
  assign out_ch.value = out_value_q;

  // cross-skip samples: clamp skip_bits and mask the low state bits
  always_comb begin
    if (int'(skip_bits_q) > int'(MCB)) begin
      k_eff = 4'(MCB);
    end else begin
      k_eff = skip_bits_q;
    end
    mask_full = (32'd1 << k_eff) - 32'd1;
    smp_a     = lfsr_a_q[MCB-1:0] & mask_full[MCB-1:0];
    smp_b     = lfsr_b_q[MCB-1:0] & mask_full[MCB-1:0];
  end

  // steer the shared unit to the LFSR being advanced
  always_comb begin
    if (st_q == ST_RUN_B) begin
      adv_in        = lfsr_b_q;
      adv_cfg.width = width_b_q;
      adv_cfg.taps  = taps_b_q;
    end else begin
      adv_in        = lfsr_a_q;
      adv_cfg.width = width_a_q;
      adv_cfg.taps  = taps_a_q;
    end
  end

  always_comb begin
    case (cmd_q)
      dlcs_pkg::CMD_STEP_A: result = lfsr_a_q;
      dlcs_pkg::CMD_STEP_B: result = lfsr_b_q;
      dlcs_pkg::CMD_CROSS:  result = lfsr_a_q ^ lfsr_b_q;
      default:              result = '0;
    endcase
  end

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    lfsr_a_d    = lfsr_a_q;
    lfsr_b_d    = lfsr_b_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;

    // drop the result beat once taken
    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d = in_cmd;
          case (in_cmd)
            dlcs_pkg::CMD_STEP_A: begin
              cnt_d = CNT_W'(in_ch.skip_count) + CNT_W'(1);
              st_d  = ST_RUN_A;
            end
            dlcs_pkg::CMD_STEP_B: begin
              cnt_d = CNT_W'(in_ch.skip_count) + CNT_W'(1);
              st_d  = ST_RUN_B;
            end
            dlcs_pkg::CMD_CROSS: begin
              // A runs B's sample plus one, then B runs A's sample plus one
              cnt_d  = CNT_W'(smp_b) + CNT_W'(1);
              pend_d = CNT_W'(smp_a) + CNT_W'(1);
              st_d   = ST_RUN_A;
            end
            default: begin
              st_d = ST_DONE;
            end
          endcase
        end
      end
      ST_RUN_A: begin
        lfsr_a_d = adv_out;
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          if (cmd_q == dlcs_pkg::CMD_CROSS) begin
            cnt_d = pend_q;
            st_d  = ST_RUN_B;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_RUN_B: begin
        lfsr_b_d = adv_out;
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_value_d = result;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // seed writes load the state directly
    if (cfg_we_i && (cfg_idx_i == dlcs_pkg::REG_SEED_A)) begin
      lfsr_a_d = cfg_data_i;
    end
    if (cfg_we_i && (cfg_idx_i == dlcs_pkg::REG_SEED_B)) begin
      lfsr_b_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_a_q   <= dlcs_pkg::WIDTH_A_RST;
      taps_a_q    <= dlcs_pkg::TAPS_A_RST;
      width_b_q   <= dlcs_pkg::WIDTH_B_RST;
      taps_b_q    <= dlcs_pkg::TAPS_B_RST;
      skip_bits_q <= dlcs_pkg::SKIP_BITS_RST;
    end else if (cfg_we_i) begin
      case (dlcs_pkg::reg_idx_e'(cfg_idx_i))
        dlcs_pkg::REG_WIDTH_A:   width_a_q   <= cfg_data_i[dlcs_pkg::WIDTH_W-1:0];
        dlcs_pkg::REG_TAPS_A:    taps_a_q    <= cfg_data_i;
        dlcs_pkg::REG_WIDTH_B:   width_b_q   <= cfg_data_i[dlcs_pkg::WIDTH_W-1:0];
        dlcs_pkg::REG_TAPS_B:    taps_b_q    <= cfg_data_i;
        dlcs_pkg::REG_SKIP_BITS: skip_bits_q <= cfg_data_i[dlcs_pkg::SKIPB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cmd_q       <= dlcs_pkg::CMD_NOP;
      cnt_q       <= '0;
      pend_q      <= '0;
      lfsr_a_q    <= dlcs_pkg::SEED_A_RST;
      lfsr_b_q    <= dlcs_pkg::SEED_B_RST;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cmd_q       <= cmd_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      lfsr_a_q    <= lfsr_a_d;
      lfsr_b_q    <= lfsr_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

endmodule

>>> sv/dlcs_adv_unit.sv
// ----------------------------------------------------------------------------
// dlcs_adv_unit: one Galois LFSR advance
// Refill a zero state, then shift right with tap feedback on bit 0.
// ----------------------------------------------------------------------------
module dlcs_adv_unit (
  input  logic [dlcs_pkg::STATE_W-1:0] state_i,
  input  dlcs_pkg::lfsr_cfg_t          cfg_i,
  output logic [dlcs_pkg::STATE_W-1:0] next_o
);

  logic [4:0]                   top;
  logic [dlcs_pkg::STATE_W-1:0] topbit;
  logic [dlcs_pkg::STATE_W-1:0] filled;

  always_comb begin
    // clamp the width to 8..32, top bit index is width-1
    if (cfg_i.width < 6'd8) begin
      top = 5'd7;
    end else if (cfg_i.width > 6'd32) begin
      top = 5'd31;
    end else begin
      top = 5'(cfg_i.width - 6'd1);
    end
    topbit = 32'd1 << top;
    filled = (state_i == '0) ? (topbit - 32'd1) : state_i;
    if (filled[0]) begin
      next_o = ((filled ^ cfg_i.taps) >> 1) | topbit;
    end else begin
      next_o = filled >> 1;
    end
  end

endmodule
